[rtl/efpf_pkg.sv]
// Shared constants, codes and memory port structs for the edge-flag polygon filler.
// No dependencies; every other file imports this package.
`default_nettype none
package efpf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int MAX_VERTICES = 64;

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int PAW        = XW + YW;
   localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int VW         = $clog2(MAX_VERTICES);
   localparam int CW         = $clog2(MAX_VERTICES + 1);
   localparam int EW         = ((XW > YW) ? XW : YW) + 3;

   // fixed field widths
   localparam int ACT_W   = 3;
   localparam int POS_W   = 10;
   localparam int FRAME_W = 11;
   localparam int TOTAL_W = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_CLOSE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FILL  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd720;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   localparam logic [1:0] FLAG_ONE = 2'd1;
   localparam logic [1:0] FLAG_SAT = 2'd2;

   typedef struct packed {
      logic           we;
      logic [PAW-1:0] waddr;
      logic           wdata;
      logic [PAW-1:0] raddr;
   } pix_port_type;

   typedef struct packed {
      logic           we;
      logic [PAW-1:0] waddr;
      logic [1:0]     wdata;
      logic [PAW-1:0] raddr;
   } flag_port_type;

   typedef struct packed {
      logic          we;
      logic [YW-1:0] waddr;
      logic          wdata;
      logic [YW-1:0] raddr;
   } par_port_type;

   typedef struct packed {
      logic          we;
      logic [VW-1:0] waddr;
      logic [XW-1:0] wx;
      logic [YW-1:0] wy;
      logic [VW-1:0] raddr;
   } vtx_port_type;

endpackage
`default_nettype wire

[rtl/efpf_vstore.sv]
// Vertex store: one synchronous memory of x/y pairs, registered read.
// Depends on efpf_pkg.
`default_nettype none
module efpf_vstore (
   input  logic                      clock,
   input  efpf_pkg::vtx_port_type    vtx_port,
   output logic [efpf_pkg::XW-1:0]   vtx_rd_x,
   output logic [efpf_pkg::YW-1:0]   vtx_rd_y
);
   import efpf_pkg::*;

   logic [XW+YW-1:0] vtx_mem [MAX_VERTICES];
   logic [XW+YW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (vtx_port.we) begin
         vtx_mem[vtx_port.waddr] <= {vtx_port.wx, vtx_port.wy};
      end
      rd_ff <= vtx_mem[vtx_port.raddr];
   end

   assign vtx_rd_x = rd_ff[XW+YW-1:YW];
   assign vtx_rd_y = rd_ff[YW-1:0];

endmodule
`default_nettype wire

[rtl/efpf_planes.sv]
// Pixel plane, edge-flag plane and row parity memories, each with one write
// and one registered read port. Depends on efpf_pkg.
`default_nettype none
module efpf_planes (
   input  logic                    clock,
   input  efpf_pkg::pix_port_type  pix_port,
   input  efpf_pkg::flag_port_type flag_port,
   input  efpf_pkg::par_port_type  par_port,
   output logic                    pix_rd,
   output logic [1:0]              flag_rd,
   output logic                    par_rd
);
   import efpf_pkg::*;

   logic       pix_mem  [PLANE_SIZE];
   logic [1:0] flag_mem [PLANE_SIZE];
   logic       par_mem  [MAX_HEIGHT];

   logic       pix_rd_ff;
   logic [1:0] flag_rd_ff;
   logic       par_rd_ff;

   always_ff @(posedge clock) begin
      if (pix_port.we) begin
         pix_mem[pix_port.waddr] <= pix_port.wdata;
      end
      pix_rd_ff <= pix_mem[pix_port.raddr];
   end

   always_ff @(posedge clock) begin
      if (flag_port.we) begin
         flag_mem[flag_port.waddr] <= flag_port.wdata;
      end
      flag_rd_ff <= flag_mem[flag_port.raddr];
   end

   always_ff @(posedge clock) begin
      if (par_port.we) begin
         par_mem[par_port.waddr] <= par_port.wdata;
      end
      par_rd_ff <= par_mem[par_port.raddr];
   end

   assign pix_rd  = pix_rd_ff;
   assign flag_rd = flag_rd_ff;
   assign par_rd  = par_rd_ff;

endmodule
`default_nettype wire

[rtl/efpf_ctrl.sv]
// Sequencer: request decode, Bresenham edge walk, vertex adjust, row fill and
// clearing sweep, driving the plane and vertex memories. Depends on efpf_pkg.
`default_nettype none
module efpf_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [efpf_pkg::ACT_W-1:0]         req_action,
   input  logic [efpf_pkg::POS_W-1:0]         req_pos_x,
   input  logic [efpf_pkg::POS_W-1:0]         req_pos_y,
   output logic                               rsp_strobe,
   output logic                               rsp_status,
   output logic                               rsp_pixel_value,
   output logic [efpf_pkg::TOTAL_W-1:0]       rsp_vertex_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [efpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [efpf_pkg::FRAME_W-1:0]       csr_wdata,
   output efpf_pkg::pix_port_type             pix_port,
   output efpf_pkg::flag_port_type            flag_port,
   output efpf_pkg::par_port_type             par_port,
   output efpf_pkg::vtx_port_type             vtx_port,
   input  logic                               pix_rd,
   input  logic [1:0]                         flag_rd,
   input  logic                               par_rd,
   input  logic [efpf_pkg::XW-1:0]            vtx_rd_x,
   input  logic [efpf_pkg::YW-1:0]            vtx_rd_y
);
   import efpf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_RD, ST_LOAD_A, ST_LOAD_B, ST_SETUP, ST_STEP, ST_BUMP,
      ST_ADJ_RP, ST_ADJ_RI, ST_ADJ_RN, ST_ADJ_DO, ST_FILL, ST_FILL_END
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               entry_ff, entry_in;
   logic               filled_ff, filled_in;
   logic [FRAME_W-1:0] width_ff, width_in;
   logic [FRAME_W-1:0] height_ff, height_in;
   logic               rsp_v_ff, rsp_v_in;
   logic               rsp_st_ff, rsp_st_in;
   logic               rsp_px_ff, rsp_px_in;
   logic [PAW-1:0]     sweep_ff, sweep_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [VW-1:0]      edge_ff, edge_in;
   logic [XW-1:0]      ax_ff, ax_in;
   logic [YW-1:0]      ay_ff, ay_in;
   logic [XW-1:0]      bx_ff, bx_in;
   logic [YW-1:0]      by_ff, by_in;
   logic [XW-1:0]      cx_ff, cx_in;
   logic [YW-1:0]      cy_ff, cy_in;
   logic [XW-1:0]      right_ff, right_in;
   logic               started_ff, started_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic signed [EW-1:0] dx_ff, dx_in;
   logic signed [EW-1:0] dy_ff, dy_in;
   logic               sxn_ff, sxn_in;
   logic               syn_ff, syn_in;
   logic [XW-1:0]      bump_x_ff, bump_x_in;
   logic [YW-1:0]      bump_y_ff, bump_y_in;
   logic [VW-1:0]      idx_ff, idx_in;
   logic [YW-1:0]      py_ff, py_in;
   logic [YW-1:0]      fr_ff, fr_in;
   logic [XW-1:0]      fc_ff, fc_in;
   logic               pv_ff, pv_in;
   logic               pfirst_ff, pfirst_in;
   logic [PAW-1:0]     paddr_ff, paddr_in;
   logic               inside_ff, inside_in;

   logic               accept;
   logic [XW:0]        frame_w;
   logic [YW:0]        frame_h;
   logic               req_in_frame;
   logic [PAW-1:0]     req_addr;
   logic [VW-1:0]      n_last;
   logic signed [EW:0] e2;
   logic signed [EW:0] dx_e;
   logic signed [EW:0] dy_e;
   logic               xs;
   logic               ys;
   logic [XW-1:0]      cx_n;
   logic [XW-1:0]      right_1;
   logic [XW-1:0]      dxu;
   logic [YW-1:0]      dyu;
   logic               mono;
   logic               ins;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign n_last    = VW'(cnt_ff - 1'b1);

   always_comb begin
      if (width_ff == '0) begin
         frame_w = (XW+1)'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         frame_w = (XW+1)'(MAX_WIDTH);
      end else begin
         frame_w = (XW+1)'(width_ff);
      end
      if (height_ff == '0) begin
         frame_h = (YW+1)'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         frame_h = (YW+1)'(MAX_HEIGHT);
      end else begin
         frame_h = (YW+1)'(height_ff);
      end
   end

   assign req_in_frame = (int'(req_pos_x) < int'(frame_w)) &&
                         (int'(req_pos_y) < int'(frame_h));
   assign req_addr     = {YW'(req_pos_y), XW'(req_pos_x)};

   // Bresenham step terms
   assign e2   = $signed({err_ff, 1'b0});
   assign dx_e = (EW+1)'(dx_ff);
   assign dy_e = (EW+1)'(dy_ff);
   assign xs   = (e2 > -dy_e);
   assign ys   = (e2 < dx_e);
   assign cx_n = xs ? (sxn_ff ? cx_ff - 1'b1 : cx_ff + 1'b1) : cx_ff;
   assign right_1 = (xs && (cx_n > right_ff)) ? cx_n : right_ff;

   assign dxu  = (ax_ff > vtx_rd_x) ? ax_ff - vtx_rd_x : vtx_rd_x - ax_ff;
   assign dyu  = (ay_ff > vtx_rd_y) ? ay_ff - vtx_rd_y : vtx_rd_y - ay_ff;

   assign mono = ((ay_ff > py_ff) && (ay_ff < vtx_rd_y)) ||
                 ((ay_ff < py_ff) && (ay_ff > vtx_rd_y));

   assign ins  = (pfirst_ff ? 1'b0 : inside_ff) ^ (flag_rd == FLAG_ONE);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      entry_in   = entry_ff;
      filled_in  = filled_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      rsp_v_in   = 1'b0;
      rsp_st_in  = rsp_st_ff;
      rsp_px_in  = rsp_px_ff;
      sweep_in   = sweep_ff;
      clr_rsp_in = clr_rsp_ff;
      edge_in    = edge_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      bx_in      = bx_ff;
      by_in      = by_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      right_in   = right_ff;
      started_in = started_ff;
      err_in     = err_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sxn_in     = sxn_ff;
      syn_in     = syn_ff;
      bump_x_in  = bump_x_ff;
      bump_y_in  = bump_y_ff;
      idx_in     = idx_ff;
      py_in      = py_ff;
      fr_in      = fr_ff;
      fc_in      = fc_ff;
      pv_in      = 1'b0;
      pfirst_in  = pfirst_ff;
      paddr_in   = paddr_ff;
      inside_in  = inside_ff;

      pix_port  = '0;
      flag_port = '0;
      par_port  = '0;
      vtx_port  = '0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_v_in  = 1'b1;
               rsp_st_in = STATUS_IGNORED;
               rsp_px_in = 1'b0;
               case (req_action)
                  ACT_ADD: begin
                     if (entry_ff && (int'(cnt_ff) < MAX_VERTICES) && req_in_frame) begin
                        vtx_port.we    = 1'b1;
                        vtx_port.waddr = VW'(cnt_ff);
                        vtx_port.wx    = XW'(req_pos_x);
                        vtx_port.wy    = YW'(req_pos_y);
                        pix_port.we    = 1'b1;
                        pix_port.waddr = req_addr;
                        pix_port.wdata = 1'b1;
                        cnt_in         = cnt_ff + 1'b1;
                        rsp_st_in      = STATUS_DONE;
                     end
                  end
                  ACT_CLOSE: begin
                     if (entry_ff && (cnt_ff > CW'(2))) begin
                        entry_in = 1'b0;
                        edge_in  = '0;
                        rsp_v_in = 1'b0;
                        state_in = ST_LOAD_A;
                     end
                  end
                  ACT_FILL: begin
                     if (!filled_ff && !entry_ff) begin
                        fr_in    = '0;
                        fc_in    = '0;
                        rsp_v_in = 1'b0;
                        state_in = ST_FILL;
                     end
                  end
                  ACT_CLEAR: begin
                     cnt_in     = '0;
                     entry_in   = 1'b1;
                     filled_in  = 1'b0;
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     rsp_v_in   = 1'b0;
                     state_in   = ST_CLR;
                  end
                  ACT_READ: begin
                     if (req_in_frame) begin
                        pix_port.raddr = req_addr;
                        rsp_v_in       = 1'b0;
                        state_in       = ST_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_RD: begin
            rsp_v_in  = 1'b1;
            rsp_st_in = STATUS_DONE;
            rsp_px_in = pix_rd;
            state_in  = ST_IDLE;
         end

         ST_CLR: begin
            pix_port.we     = 1'b1;
            pix_port.waddr  = sweep_ff;
            flag_port.we    = 1'b1;
            flag_port.waddr = sweep_ff;
            par_port.we     = (int'(sweep_ff) < MAX_HEIGHT);
            par_port.waddr  = sweep_ff[YW-1:0];
            sweep_in        = sweep_ff + 1'b1;
            if (sweep_ff == PAW'(PLANE_SIZE - 1)) begin
               rsp_v_in  = clr_rsp_ff;
               rsp_st_in = STATUS_DONE;
               rsp_px_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         ST_LOAD_A: begin
            vtx_port.raddr = edge_ff;
            state_in       = ST_LOAD_B;
         end

         ST_LOAD_B: begin
            ax_in          = vtx_rd_x;
            ay_in          = vtx_rd_y;
            vtx_port.raddr = (edge_ff == n_last) ? '0 : edge_ff + 1'b1;
            state_in       = ST_SETUP;
         end

         ST_SETUP: begin
            pix_port.we    = 1'b1;
            pix_port.waddr = {vtx_rd_y, vtx_rd_x};
            pix_port.wdata = 1'b1;
            bx_in      = vtx_rd_x;
            by_in      = vtx_rd_y;
            dx_in      = $signed(EW'(dxu));
            dy_in      = $signed(EW'(dyu));
            err_in     = $signed(EW'(dxu)) - $signed(EW'(dyu));
            sxn_in     = !(ax_ff < vtx_rd_x);
            syn_in     = !(ay_ff < vtx_rd_y);
            cx_in      = ax_ff;
            cy_in      = ay_ff;
            right_in   = ax_ff;
            started_in = 1'b0;
            state_in   = ST_STEP;
         end

         ST_STEP: begin
            if ((cx_ff == bx_ff) && (cy_ff == by_ff)) begin
               if (edge_ff == n_last) begin
                  idx_in   = VW'(1);
                  state_in = ST_ADJ_RP;
               end else begin
                  edge_in  = edge_ff + 1'b1;
                  state_in = ST_LOAD_A;
               end
            end else begin
               pix_port.we    = 1'b1;
               pix_port.waddr = {cy_ff, cx_ff};
               pix_port.wdata = 1'b1;
               err_in = err_ff - (xs ? dy_ff : EW'(0)) + (ys ? dx_ff : EW'(0));
               cx_in  = cx_n;
               right_in = right_1;
               if (ys) begin
                  cy_in      = syn_ff ? cy_ff - 1'b1 : cy_ff + 1'b1;
                  right_in   = cx_n;
                  started_in = 1'b1;
                  if (started_ff) begin
                     // flag goes on the row being left, at its rightmost x
                     flag_port.raddr = {cy_ff, right_1};
                     par_port.raddr  = cy_ff;
                     bump_x_in       = right_1;
                     bump_y_in       = cy_ff;
                     state_in        = ST_BUMP;
                  end
               end
            end
         end

         ST_BUMP: begin
            flag_port.we    = 1'b1;
            flag_port.waddr = {bump_y_ff, bump_x_ff};
            flag_port.wdata = (flag_rd >= FLAG_SAT) ? FLAG_SAT : flag_rd + 1'b1;
            par_port.we     = 1'b1;
            par_port.waddr  = bump_y_ff;
            par_port.wdata  = !par_rd;
            state_in        = ST_STEP;
         end

         ST_ADJ_RP: begin
            vtx_port.raddr = (idx_ff == '0) ? n_last : idx_ff - 1'b1;
            state_in       = ST_ADJ_RI;
         end

         ST_ADJ_RI: begin
            py_in          = vtx_rd_y;
            vtx_port.raddr = idx_ff;
            state_in       = ST_ADJ_RN;
         end

         ST_ADJ_RN: begin
            ax_in          = vtx_rd_x;
            ay_in          = vtx_rd_y;
            par_port.raddr = vtx_rd_y;
            vtx_port.raddr = (idx_ff == n_last) ? '0 : idx_ff + 1'b1;
            state_in       = ST_ADJ_DO;
         end

         ST_ADJ_DO: begin
            if (mono || par_rd) begin
               flag_port.we    = 1'b1;
               flag_port.waddr = {ay_ff, ax_ff};
               flag_port.wdata = FLAG_ONE;
            end
            if (par_rd) begin
               par_port.we    = 1'b1;
               par_port.waddr = ay_ff;
               par_port.wdata = 1'b0;
            end
            // order: 1 .. n-2, then n-1, then 0
            if (idx_ff == '0) begin
               rsp_v_in  = 1'b1;
               rsp_st_in = STATUS_DONE;
               rsp_px_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = (idx_ff == n_last) ? '0 : idx_ff + 1'b1;
               state_in = ST_ADJ_RP;
            end
         end

         ST_FILL: begin
            if (pv_ff) begin
               inside_in      = ins;
               pix_port.we    = ins;
               pix_port.waddr = paddr_ff;
               pix_port.wdata = 1'b1;
            end
            flag_port.raddr = {fr_ff, fc_ff};
            pv_in           = 1'b1;
            pfirst_in       = (fc_ff == '0);
            paddr_in        = {fr_ff, fc_ff};
            if (fc_ff == XW'(frame_w - 1'b1)) begin
               fc_in = '0;
               if (fr_ff == YW'(frame_h - 1'b1)) begin
                  state_in = ST_FILL_END;
               end else begin
                  fr_in = fr_ff + 1'b1;
               end
            end else begin
               fc_in = fc_ff + 1'b1;
            end
         end

         ST_FILL_END: begin
            // drain the last pixel
            if (pv_ff) begin
               inside_in      = ins;
               pix_port.we    = ins;
               pix_port.waddr = paddr_ff;
               pix_port.wdata = 1'b1;
            end
            filled_in = 1'b1;
            rsp_v_in  = 1'b1;
            rsp_st_in = STATUS_DONE;
            rsp_px_in = 1'b0;
            state_in  = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         cnt_ff     <= '0;
         entry_ff   <= 1'b1;
         filled_ff  <= 1'b0;
         width_ff   <= FRAME_RESET;
         height_ff  <= FRAME_RESET;
         rsp_v_ff   <= 1'b0;
         sweep_ff   <= '0;
         clr_rsp_ff <= 1'b0;
         pv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         entry_ff   <= entry_in;
         filled_ff  <= filled_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         rsp_v_ff   <= rsp_v_in;
         sweep_ff   <= sweep_in;
         clr_rsp_ff <= clr_rsp_in;
         pv_ff      <= pv_in;
      end
      rsp_st_ff  <= rsp_st_in;
      rsp_px_ff  <= rsp_px_in;
      edge_ff    <= edge_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      right_ff   <= right_in;
      started_ff <= started_in;
      err_ff     <= err_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sxn_ff     <= sxn_in;
      syn_ff     <= syn_in;
      bump_x_ff  <= bump_x_in;
      bump_y_ff  <= bump_y_in;
      idx_ff     <= idx_in;
      py_ff      <= py_in;
      fr_ff      <= fr_in;
      fc_ff      <= fc_in;
      pfirst_ff  <= pfirst_in;
      paddr_ff   <= paddr_in;
      inside_ff  <= inside_in;
   end

   assign rsp_strobe       = rsp_v_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_pixel_value  = rsp_px_ff;
   assign rsp_vertex_total = TOTAL_W'(cnt_ff);

`ifndef SYNTH
   a_accept_answered: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("accepted request neither answered nor in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= MAX_VERTICES)
      else $error("vertex count above store depth");

   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      !(entry_ff && filled_ff))
      else $error("filled while still in entry mode");

   a_close_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD_A) |-> (cnt_ff > CW'(2)))
      else $error("edge walk with fewer than three vertices");
`endif

endmodule
`default_nettype wire

[rtl/edge_flag_polygon_filler.sv]
// Edge-flag polygon filler: 1-bit pixel plane filled from a vertex list.
// A read goes through the pixel plane; fill sweeps the frame, clear the whole plane. Close
// walks each edge with Bresenham, bumping flag and parity on each row left after the first,
// then adjusts every vertex. One request at a time; a new one is taken in the result cycle.
// Synchronous reset starts a clearing sweep with busy high and no result. Depends on
// efpf_pkg, efpf_ctrl, efpf_planes, efpf_vstore.
`default_nettype none
module edge_flag_polygon_filler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [efpf_pkg::ACT_W-1:0]         req_action,
   input  logic [efpf_pkg::POS_W-1:0]         req_pos_x,
   input  logic [efpf_pkg::POS_W-1:0]         req_pos_y,
   output logic                               rsp_strobe,
   output logic                               rsp_status,
   output logic                               rsp_pixel_value,
   output logic [efpf_pkg::TOTAL_W-1:0]       rsp_vertex_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [efpf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [efpf_pkg::FRAME_W-1:0]       csr_wdata
);
   import efpf_pkg::*;

   pix_port_type  pix_port;
   flag_port_type flag_port;
   par_port_type  par_port;
   vtx_port_type  vtx_port;
   logic          pix_rd;
   logic [1:0]    flag_rd;
   logic          par_rd;
   logic [XW-1:0] vtx_rd_x;
   logic [YW-1:0] vtx_rd_y;

   efpf_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_vertex_total (rsp_vertex_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pix_port         (pix_port),
      .flag_port        (flag_port),
      .par_port         (par_port),
      .vtx_port         (vtx_port),
      .pix_rd           (pix_rd),
      .flag_rd          (flag_rd),
      .par_rd           (par_rd),
      .vtx_rd_x         (vtx_rd_x),
      .vtx_rd_y         (vtx_rd_y)
   );

   efpf_planes u_planes (
      .clock     (clock),
      .pix_port  (pix_port),
      .flag_port (flag_port),
      .par_port  (par_port),
      .pix_rd    (pix_rd),
      .flag_rd   (flag_rd),
      .par_rd    (par_rd)
   );

   efpf_vstore u_vstore (
      .clock    (clock),
      .vtx_port (vtx_port),
      .vtx_rd_x (vtx_rd_x),
      .vtx_rd_y (vtx_rd_y)
   );

endmodule
`default_nettype wire

[dv/edge_flag_polygon_filler_tb.sv]
// Self-checking bench for edge_flag_polygon_filler: polygon entry, close, fill, clear and
// reads, checked against an in-bench bitmap predictor. Depends on efpf_pkg and the RTL.
`default_nettype none
module edge_flag_polygon_filler_tb;
   import efpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 3_500_000;
   localparam int PITCH = MAX_WIDTH;

   typedef struct {
      logic [ACT_W-1:0] act;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } request_type;

   typedef struct {
      logic               status;
      logic               pix;
      logic [TOTAL_W-1:0] total;
   } reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [ACT_W-1:0]     req_action = '0;
   logic [POS_W-1:0]     req_pos_x = '0;
   logic [POS_W-1:0]     req_pos_y = '0;
   logic                 rsp_strobe;
   logic                 rsp_status;
   logic                 rsp_pixel_value;
   logic [TOTAL_W-1:0]   rsp_vertex_total;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FRAME_W-1:0]   csr_wdata = '0;

   request_type pending_requests[$];
   reply_type   expected_replies[$];
   int       sender_idle_pct = 18;
   int       error_count = 0;
   int       quiet_cycles = 0;

   // predictor state
   logic [FRAME_W-1:0] width_reg = FRAME_RESET;
   logic [FRAME_W-1:0] height_reg = FRAME_RESET;
   logic [POS_W-1:0]   vtx_x [MAX_VERTICES];
   logic [POS_W-1:0]   vtx_y [MAX_VERTICES];
   int                 vtx_count = 0;
   bit                 bitmap [PLANE_SIZE];
   bit [1:0]           flags [PLANE_SIZE];
   bit                 parity [MAX_HEIGHT];
   bit                 entering = 1'b1;
   bit                 filled = 1'b0;

   edge_flag_polygon_filler uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_pixel_value(rsp_pixel_value), .rsp_vertex_total(rsp_vertex_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int frame_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int frame_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   function automatic bit on_plane(int x, int y);
      return x >= 0 && y >= 0 && x < MAX_WIDTH && y < MAX_HEIGHT;
   endfunction

   function automatic void set_pixel(int x, int y);
      if (on_plane(x, y)) bitmap[y * PITCH + x] = 1'b1;
   endfunction

   function automatic void trace_edge(int ax, int ay, int bx, int by);
      int cx, cy, ny, right, dx, dy, sx, sy, err, e2;
      bit started, stepped;
      cx = ax; cy = ay; ny = ay; right = ax; started = 0;
      dx = (bx > ax) ? bx - ax : ax - bx;
      dy = (by > ay) ? by - ay : ay - by;
      sx = (ax < bx) ? 1 : -1;
      sy = (ay < by) ? 1 : -1;
      err = dx - dy;
      set_pixel(bx, by);
      while (cx != bx || cy != by) begin
         e2 = err * 2;
         stepped = 0;
         set_pixel(cx, cy);
         if (e2 > -dy) begin
            err -= dy;
            cx += sx;
            if (cx > right) right = cx;
         end
         if (e2 < dx) begin
            err += dx;
            ny += sy;
            stepped = 1;
         end
         if (stepped) begin
            // the row being left gets a flag at its rightmost reached x
            if (started) begin
               if (on_plane(right, cy) && flags[cy * PITCH + right] < FLAG_SAT)
                  flags[cy * PITCH + right] += 1;
               if (cy >= 0 && cy < MAX_HEIGHT) parity[cy] ^= 1'b1;
            end
            right = cx;
            started = 1;
         end
         cy = ny;
      end
   endfunction

   function automatic void settle_vertex(int i, int p, int n);
      int x, y, a, b;
      x = vtx_x[i]; y = vtx_y[i];
      a = y - int'(vtx_y[p]);
      b = y - int'(vtx_y[n]);
      if (!on_plane(x, y)) return;
      if ((a > 0 && b < 0) || (a < 0 && b > 0)) flags[y * PITCH + x] = FLAG_ONE;
      if (parity[y]) begin
         flags[y * PITCH + x] = FLAG_ONE;
         parity[y] ^= 1'b1;
      end
   endfunction

   function automatic void wipe_planes();
      for (int k = 0; k < PLANE_SIZE; k++) begin
         bitmap[k] = 1'b0;
         flags[k] = 2'd0;
      end
      for (int r = 0; r < MAX_HEIGHT; r++) parity[r] = 1'b0;
      vtx_count = 0;
      entering = 1'b1;
      filled = 1'b0;
   endfunction

   function automatic reply_type apply_request(request_type rq);
      reply_type rp;
      int n;
      bit in_span;
      rp.status = STATUS_IGNORED;
      rp.pix = 1'b0;
      case (rq.act)
         ACT_ADD: begin
            if (entering && vtx_count < MAX_VERTICES &&
                rq.x < frame_width() && rq.y < frame_height()) begin
               vtx_x[vtx_count] = rq.x;
               vtx_y[vtx_count] = rq.y;
               vtx_count++;
               set_pixel(rq.x, rq.y);
               rp.status = STATUS_DONE;
            end
         end
         ACT_CLOSE: begin
            if (entering && vtx_count > 2) begin
               entering = 1'b0;
               n = vtx_count;
               for (int i = 0; i + 1 < n; i++)
                  trace_edge(vtx_x[i], vtx_y[i], vtx_x[i+1], vtx_y[i+1]);
               trace_edge(vtx_x[n-1], vtx_y[n-1], vtx_x[0], vtx_y[0]);
               for (int i = 1; i + 1 < n; i++) settle_vertex(i, i - 1, i + 1);
               settle_vertex(n - 1, n - 2, 0);
               settle_vertex(0, n - 1, 1);
               rp.status = STATUS_DONE;
            end
         end
         ACT_FILL: begin
            if (!filled && !entering) begin
               for (int r = 0; r < frame_height(); r++) begin
                  in_span = 0;
                  for (int c = 0; c < frame_width(); c++) begin
                     if (flags[r * PITCH + c] == FLAG_ONE) in_span = !in_span;
                     if (in_span) bitmap[r * PITCH + c] = 1'b1;
                  end
               end
               filled = 1'b1;
               rp.status = STATUS_DONE;
            end
         end
         ACT_CLEAR: begin
            wipe_planes();
            rp.status = STATUS_DONE;
         end
         ACT_READ: begin
            if (rq.x < frame_width() && rq.y < frame_height()) begin
               rp.pix = bitmap[rq.y * PITCH + rq.x];
               rp.status = STATUS_DONE;
            end
         end
         default: ;
      endcase
      rp.total = vtx_count[TOTAL_W-1:0];
      return rp;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // driver: accept, predict, then offer the next request or idle
   always @(posedge clock) begin
      request_type head;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            head = pending_requests.pop_front();
            expected_replies = {expected_replies, apply_request(head)};
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_requests.size() > 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            start <= 1'b1;
            req_action <= pending_requests[0].act;
            req_pos_x <= pending_requests[0].x;
            req_pos_y <= pending_requests[0].y;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("reply with no request outstanding");
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %b, want %b", rsp_status, want.status));
            if (rsp_pixel_value !== want.pix)
               report_mismatch($sformatf("pixel %b, want %b", rsp_pixel_value, want.pix));
            if (rsp_vertex_total !== want.total)
               report_mismatch($sformatf("vertex total %0d, want %0d",
                                         rsp_vertex_total, want.total));
         end
      end
   end

   // watchdog: counts cycles with no handshake at all
   always @(posedge clock) begin
      if (!((start && !busy) || rsp_strobe || (csr_valid && csr_ready))) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end else begin
         quiet_cycles <= 0;
      end
   end

   task automatic queue_req(input logic [ACT_W-1:0] act, input int x, input int y);
      request_type rq;
      rq.act = act;
      rq.x = x[POS_W-1:0];
      rq.y = y[POS_W-1:0];
      pending_requests = {pending_requests, rq};
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_replies.size() > 0 || busy || start)
         @(posedge clock);
   endtask

   task automatic write_frame(input logic [CSR_IDX_W-1:0] idx, input int value);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[FRAME_W-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_WIDTH) width_reg = value[FRAME_W-1:0];
      else height_reg = value[FRAME_W-1:0];
      csr_valid <= 1'b0;
   endtask

   // one polygon: random vertices with noise, then close, fill and probe reads
   task automatic polygon_session(input int adds, input int xspan, input int yspan);
      int r;
      for (int i = 0; i < adds; i++) begin
         r = $urandom_range(0, 99);
         if (r < 75)
            queue_req(ACT_ADD, $urandom_range(0, xspan - 1), $urandom_range(0, yspan - 1));
         else if (r < 85)
            queue_req(ACT_READ, $urandom_range(0, 1023), $urandom_range(0, 1023));
         else if (r < 92)
            queue_req(ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
         else
            queue_req(ACT_W'($urandom_range(ACT_READ + 1, 7)), $urandom_range(0, 1023),
                      $urandom_range(0, 1023));
      end
      queue_req(ACT_CLOSE, $urandom_range(0, 1023), $urandom_range(0, 1023));
      for (int i = 0; i < 6; i++)
         queue_req(ACT_READ, $urandom_range(0, xspan - 1), $urandom_range(0, yspan - 1));
      queue_req(ACT_FILL, 0, 0);
      for (int i = 0; i < 12; i++)
         queue_req(ACT_READ, $urandom_range(0, xspan - 1), $urandom_range(0, yspan - 1));
      queue_req(ACT_FILL, 0, 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: small frame, refusals, one polygon, fill and clear
      sender_idle_pct = 18;
      write_frame(CSR_WIDTH, 16);
      write_frame(CSR_HEIGHT, 16);
      queue_req(ACT_READ, 0, 0);
      queue_req(ACT_READ, 1023, 1023);
      queue_req(3'd5, 1023, 0);
      queue_req(3'd7, 0, 1023);
      queue_req(ACT_FILL, 0, 0);
      queue_req(ACT_CLOSE, 0, 0);
      queue_req(ACT_ADD, 16, 0);
      queue_req(ACT_ADD, 0, 16);
      queue_req(ACT_ADD, 2, 1);
      queue_req(ACT_ADD, 12, 3);
      queue_req(ACT_CLOSE, 0, 0);
      queue_req(ACT_ADD, 14, 12);
      queue_req(ACT_ADD, 5, 14);
      queue_req(ACT_ADD, 1, 8);
      queue_req(ACT_ADD, 15, 15);
      queue_req(ACT_CLOSE, 0, 0);
      queue_req(ACT_ADD, 3, 3);
      queue_req(ACT_CLOSE, 0, 0);
      queue_req(ACT_FILL, 0, 0);
      queue_req(ACT_FILL, 0, 0);
      queue_req(ACT_READ, 7, 7);
      queue_req(ACT_READ, 15, 15);
      queue_req(ACT_READ, 3, 9);
      queue_req(ACT_CLEAR, 0, 0);
      queue_req(ACT_READ, 7, 7);

      // one column, tallest frame
      write_frame(CSR_WIDTH, 0);
      write_frame(CSR_HEIGHT, 2047);
      sender_idle_pct = 69;
      polygon_session(8, 1, 1024);
      drain();
      write_frame(CSR_WIDTH, 1024);
      write_frame(CSR_HEIGHT, 32);
      queue_req(ACT_CLEAR, 0, 0);

      // noisy polygon on a wide, shallow frame, then adds after the fill
      sender_idle_pct = 0;
      polygon_session(36, 1024, 32);
      for (int i = 0; i < 4; i++)
         queue_req(ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 31));
      drain();
      repeat (64) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
